>>> hw/rtl/vsd_pkg.sv
package vsd_pkg;

    localparam int CHAR_W = 8;
    localparam int SLOT_W = 6;
    localparam int CFG_W  = 7;

    localparam logic [CFG_W-1:0] ALPHA_SIZE_RESET = 7'd26;
    localparam logic [CFG_W-1:0] KEY_LENGTH_RESET = 7'd1;

    // register index, taken from paddr[2]
    localparam logic REG_ALPHA_SIZE = 1'b0;
    localparam logic REG_KEY_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        REQ_DECODE     = 2'd0,
        REQ_LOAD_ALPHA = 2'd1,
        REQ_LOAD_KEY   = 2'd2,
        REQ_RESTART    = 2'd3
    } req_t;

    typedef struct packed {
        req_t              req;
        logic [SLOT_W-1:0] slot;
        logic [CHAR_W-1:0] ch;
    } vsd_item_t;

endpackage

>>> hw/rtl/vsd_ram.sv
module vsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // hold the last read data while no read is issued
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/vigenere_stream_decrypt_unit.sv
// Vigenere decryption of a character stream over an alphabet loaded at run
// time. The unit takes one request per clock cycle, of any kind. For a decode
// request the key memory is read at the current key position on the accepting
// edge, the next cycle holds the parallel compare of key and cipher character
// against a register copy of the alphabet, and the alphabet memory, read at the
// difference of the two indices in the stage after that, fills the result
// register. Load and restart requests give no result. The input side stalls
// only when the result register is full and m_tready is low and the stages
// behind it are full as well. There is no clearing pass after reset;
// alphabet and key entries must be loaded before they are used. Registers:
// alphabet_size at byte address 0, key_length at byte address 4.
module vigenere_stream_decrypt_unit
    import vsd_pkg::*;
#(
    parameter int ALPHA_MAX = 64,
    parameter int KEY_MAX   = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] entry_index, [13:6] char_value, [15:14] zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] plain_char
    output logic [0:0]  m_tuser,   // [0] not_found

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(ALPHA_MAX);
    localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    // configuration
    logic [CFG_W-1:0] alphabet_size_reg;
    logic [CFG_W-1:0] key_length_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_KEY_LENGTH) ? {25'd0, key_length_reg}
                                                    : {25'd0, alphabet_size_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alphabet_size_reg <= ALPHA_SIZE_RESET;
            key_length_reg    <= KEY_LENGTH_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_ALPHA_SIZE: alphabet_size_reg <= pwdata[CFG_W-1:0];
                REG_KEY_LENGTH: key_length_reg    <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    // stage control
    logic      s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic      en1, en2, en3;
    logic      accept;
    vsd_item_t in_item;

    assign en3      = !s3_valid_reg || m_tready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && en1;

    assign in_item.req  = req_t'(s_tuser);
    assign in_item.slot = s_tdata[SLOT_W-1:0];
    assign in_item.ch   = s_tdata[SLOT_W+CHAR_W-1:SLOT_W];

    // active sizes
    logic [8:0] n_act;
    logic [8:0] kl_min;
    logic [8:0] klen;

    assign n_act  = ({2'd0, alphabet_size_reg} > 9'(ALPHA_MAX)) ? 9'(ALPHA_MAX)
                                                                : {2'd0, alphabet_size_reg};
    assign kl_min = (key_length_reg == '0) ? 9'd1 : {2'd0, key_length_reg};
    assign klen   = (kl_min > 9'(KEY_MAX)) ? 9'(KEY_MAX) : kl_min;

    // key position
    logic [KW-1:0] key_position_reg;
    logic [KW-1:0] key_position_next;
    logic [8:0]    pos_now;
    logic [8:0]    pos_cur;
    logic [8:0]    pos_inc;

    assign pos_now = 9'(key_position_reg);
    assign pos_cur = (pos_now < klen) ? pos_now : 9'd0;
    assign pos_inc = pos_cur + 9'd1;

    always_comb begin
        key_position_next = key_position_reg;
        if (accept && in_item.req == REQ_DECODE) begin
            key_position_next = (pos_inc >= klen) ? '0 : KW'(pos_inc);
        end else if (accept && in_item.req == REQ_RESTART) begin
            key_position_next = '0;
        end
    end

    // key memory: written and read at request time
    logic [CHAR_W-1:0] key_char;
    logic              key_we;

    assign key_we = accept && in_item.req == REQ_LOAD_KEY && int'(in_item.slot) < KEY_MAX;

    vsd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (KEY_MAX)
    ) u_key_ram (
        .clk   (aclk),
        .we    (key_we),
        .waddr (KW'(in_item.slot)),
        .wdata (in_item.ch),
        .re    (accept && in_item.req == REQ_DECODE),
        .raddr (KW'(pos_cur)),
        .rdata (key_char)
    );

    // register copy of the alphabet for the parallel compare
    logic [CHAR_W-1:0] alpha_cam_reg [ALPHA_MAX];

    always_ff @(posedge aclk) begin
        if (accept && in_item.req == REQ_LOAD_ALPHA && int'(in_item.slot) < ALPHA_MAX) begin
            alpha_cam_reg[AW'(in_item.slot)] <= in_item.ch;
        end
    end

    // stage 1: locate key and cipher character
    vsd_item_t s1_item_reg;
    logic      key_hit, ciph_hit;
    logic [AW-1:0] key_idx, ciph_idx;

    always_comb begin
        key_hit  = 1'b0;
        ciph_hit = 1'b0;
        key_idx  = '0;
        ciph_idx = '0;
        // walk downwards so the lowest match wins
        for (int i = ALPHA_MAX - 1; i >= 0; i--) begin
            if (9'(i) < n_act && alpha_cam_reg[i] == key_char) begin
                key_hit = 1'b1;
                key_idx = AW'(i);
            end
            if (9'(i) < n_act && alpha_cam_reg[i] == s1_item_reg.ch) begin
                ciph_hit = 1'b1;
                ciph_idx = AW'(i);
            end
        end
    end

    // stage 2: index difference and alphabet memory access
    vsd_item_t     s2_item_reg;
    logic          s2_hit_reg;
    logic [AW-1:0] s2_kidx_reg;
    logic [AW-1:0] s2_cidx_reg;
    logic [8:0]    cidx9, kidx9, plain_idx;
    logic          alpha_we, alpha_re;
    logic [CHAR_W-1:0] alpha_data;

    assign cidx9     = 9'(s2_cidx_reg);
    assign kidx9     = 9'(s2_kidx_reg);
    assign plain_idx = (cidx9 >= kidx9) ? (cidx9 - kidx9) : (cidx9 + n_act - kidx9);

    // writes go in order with reads at this stage, so a later load cannot
    // overtake an earlier decode
    assign alpha_we = s2_valid_reg && en3 && s2_item_reg.req == REQ_LOAD_ALPHA
                      && int'(s2_item_reg.slot) < ALPHA_MAX;
    assign alpha_re = s2_valid_reg && en3 && s2_item_reg.req == REQ_DECODE;

    vsd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (ALPHA_MAX)
    ) u_alpha_ram (
        .clk   (aclk),
        .we    (alpha_we),
        .waddr (AW'(s2_item_reg.slot)),
        .wdata (s2_item_reg.ch),
        .re    (alpha_re),
        .raddr (AW'(plain_idx)),
        .rdata (alpha_data)
    );

    // stage 3: result register
    logic s3_miss_reg;

    assign m_tvalid   = s3_valid_reg;
    assign m_tdata    = s3_miss_reg ? '0 : alpha_data;
    assign m_tuser[0] = s3_miss_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            key_position_reg <= '0;
        end else begin
            key_position_reg <= key_position_next;
            if (en1) begin
                s1_valid_reg <= s_tvalid;
            end
            if (en2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            // drop requests that give no result
            if (en3) begin
                s3_valid_reg <= s2_valid_reg && s2_item_reg.req == REQ_DECODE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_item_reg <= in_item;
        end
        if (en2) begin
            s2_item_reg <= s1_item_reg;
            s2_hit_reg  <= key_hit && ciph_hit;
            s2_kidx_reg <= key_idx;
            s2_cidx_reg <= ciph_idx;
        end
        if (en3) begin
            s3_miss_reg <= !s2_hit_reg;
        end
    end

endmodule

>>> hw/rtl/vsd_checker.sv
module vsd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a failed lookup gives a zero character
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
        else $error("not_found result with non-zero character");

    // reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // with no result pending the pipeline is free to take a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && s_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind vigenere_stream_decrypt_unit vsd_checker u_vsd_checker (.*);
